// ----- rtl/ptsc_pkg.sv -----
// Shared widths, constants and types of the pan/tilt step controller.
package ptsc_pkg;

  // Width of a target coordinate.
  localparam int COORD_WIDTH = 10;
  // Width of a servo angle.
  localparam int ANGLE_WIDTH = 8;

  // Fixed register widths.
  localparam int CTR_W   = 10;
  localparam int DZ_W    = 8;
  localparam int LIMIT_W = 8;

  // Signed width that holds a coordinate minus a center.
  localparam int CALC_W = ((COORD_WIDTH > CTR_W) ? COORD_WIDTH : CTR_W) + 1;
  // Signed width of a step and of an angle plus a step.
  localparam int STEP_W = 5;
  localparam int SUM_W  = ANGLE_WIDTH + 2;

  // Step sizes.
  localparam logic signed [STEP_W-1:0] STEP_FAR    = 5'sd15;
  localparam logic signed [STEP_W-1:0] STEP_MID    = 5'sd10;
  localparam logic signed [STEP_W-1:0] STEP_NEAR   = 5'sd5;
  localparam logic signed [STEP_W-1:0] MANUAL_BIAS = 5'sd3;
  localparam logic [COORD_WIDTH-1:0]   MANUAL_LO   = COORD_WIDTH'(1);
  localparam logic [COORD_WIDTH-1:0]   MANUAL_HI   = COORD_WIDTH'(5);

  // Angle after reset, mid travel.
  localparam logic [ANGLE_WIDTH-1:0] ANGLE_RESET = ANGLE_WIDTH'(90);

  // Stream payload widths, padded to whole bytes.
  localparam int IN_W      = 2 * COORD_WIDTH;
  localparam int IN_DATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W      = 2 + 2 * ANGLE_WIDTH;
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

  // Configuration port.
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_DEAD_ZONE   = 3'd2,
    REG_MANUAL_MODE = 3'd3,
    REG_PAN_MIN     = 3'd4,
    REG_PAN_MAX     = 3'd5,
    REG_TILT_MIN    = 3'd6,
    REG_TILT_MAX    = 3'd7
  } reg_idx_e;

  // Per-axis settings.
  typedef struct packed {
    logic [CTR_W-1:0]   center;
    logic [LIMIT_W-1:0] lo;
    logic [LIMIT_W-1:0] hi;
  } axis_cfg_t;

  // Per-axis outcome.
  typedef struct packed {
    logic                   outside;
    logic [ANGLE_WIDTH-1:0] angle;
  } axis_res_t;

endpackage

// ----- rtl/ptsc_axis.sv -----
// One axis of the pan/tilt step controller: offset, dead zone, step and clamp.
module ptsc_axis import ptsc_pkg::*; (
  input  logic [COORD_WIDTH-1:0] coord_i,
  input  axis_cfg_t              cfg_i,
  input  logic [DZ_W-1:0]        dead_zone_i,
  input  logic                   manual_i,
  input  logic [ANGLE_WIDTH-1:0] angle_i,
  output axis_res_t              res_o
);

  logic signed [CALC_W-1:0] offset;
  logic [CALC_W-1:0]        mag;
  logic                     offset_pos;
  logic signed [STEP_W-1:0] step;
  logic signed [SUM_W-1:0]  ang_ext;
  logic signed [SUM_W-1:0]  step_ext;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  lo_ext;
  logic signed [SUM_W-1:0]  hi_ext;

  // Signed offset from the center and its magnitude.
  always_comb begin
    offset     = signed'(CALC_W'(coord_i) - CALC_W'(cfg_i.center));
    mag        = offset[CALC_W-1] ? unsigned'(-offset) : unsigned'(offset);
    offset_pos = !offset[CALC_W-1] && (offset != '0);
  end

  // Step size: manual code or distance band.
  always_comb begin
    if (manual_i) begin
      if ((coord_i >= MANUAL_LO) && (coord_i <= MANUAL_HI)) begin
        step = signed'({2'b00, coord_i[2:0]}) - MANUAL_BIAS;
      end else begin
        step = '0;
      end
    end else if (mag > CALC_W'(cfg_i.center >> 1)) begin
      step = STEP_FAR;
    end else if (mag > CALC_W'(cfg_i.center >> 2)) begin
      step = STEP_MID;
    end else begin
      step = STEP_NEAR;
    end
  end

  // Move against the offset's sign, then clamp with the lower limit first.
  always_comb begin
    ang_ext  = signed'(SUM_W'(angle_i));
    step_ext = SUM_W'(step);
    sum      = offset_pos ? (ang_ext - step_ext) : (ang_ext + step_ext);
    lo_ext   = signed'(SUM_W'(cfg_i.lo));
    hi_ext   = signed'(SUM_W'(cfg_i.hi));
    res_o.outside = mag > CALC_W'(dead_zone_i);
    if (sum < lo_ext) begin
      res_o.angle = ANGLE_WIDTH'(cfg_i.lo);
    end else if (sum > hi_ext) begin
      res_o.angle = ANGLE_WIDTH'(cfg_i.hi);
    end else begin
      res_o.angle = sum[ANGLE_WIDTH-1:0];
    end
  end

endmodule

// ----- rtl/pan_tilt_step_controller.sv -----
// Top level of the pan/tilt step controller: stream ports, registers, state.
//
// Each transaction on the input stream carries a target position; the block
// answers with exactly one result transaction holding the centered flag, the
// position-sent flag and the pan and tilt angles after the step. An accepted
// item moves into the input register, the per-axis offset, step and clamp logic
// runs between that register and the result register, and the held angles
// update as the item moves into the result register. One item is accepted
// every cycle while the output is taken. A stalled output holds the result
// register and then the input register, and the input stream stalls once
// both are full. Configuration is to be written through the APB port while
// the stream is idle; the block itself does not enforce this. pready is
// always high.
module pan_tilt_step_controller import ptsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0 up: target_x, target_y, zero padding.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0 up: centered, position_sent, pan_angle, tilt_angle, zero padding.
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  // Configuration registers.
  logic [CTR_W-1:0]   center_x_q, center_y_q;
  logic [DZ_W-1:0]    dead_zone_q;
  logic               manual_mode_q;
  logic [LIMIT_W-1:0] pan_min_q, pan_max_q, tilt_min_q, tilt_max_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  // Pipeline and state.
  logic                   in_vld_q;
  logic [COORD_WIDTH-1:0] tx_q, ty_q;
  logic                   out_vld_q;
  logic [OUT_W-1:0]       res_q, res_d;
  logic [ANGLE_WIDTH-1:0] pan_q, pan_d, tilt_q, tilt_d;
  logic                   in_take, advance;
  axis_cfg_t              pan_cfg, tilt_cfg;
  axis_res_t              pan_res, tilt_res;
  logic                   any_out;

  // Register write decode.
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q    <= CTR_W'(160);
      center_y_q    <= CTR_W'(120);
      dead_zone_q   <= DZ_W'(10);
      manual_mode_q <= 1'b0;
      pan_min_q     <= '0;
      pan_max_q     <= LIMIT_W'(180);
      tilt_min_q    <= '0;
      tilt_max_q    <= LIMIT_W'(180);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CENTER_X:    center_x_q    <= pwdata[CTR_W-1:0];
        REG_CENTER_Y:    center_y_q    <= pwdata[CTR_W-1:0];
        REG_DEAD_ZONE:   dead_zone_q   <= pwdata[DZ_W-1:0];
        REG_MANUAL_MODE: manual_mode_q <= pwdata[0];
        REG_PAN_MIN:     pan_min_q     <= pwdata[LIMIT_W-1:0];
        REG_PAN_MAX:     pan_max_q     <= pwdata[LIMIT_W-1:0];
        REG_TILT_MIN:    tilt_min_q    <= pwdata[LIMIT_W-1:0];
        REG_TILT_MAX:    tilt_max_q    <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      REG_CENTER_X:    prdata = APB_DW'(center_x_q);
      REG_CENTER_Y:    prdata = APB_DW'(center_y_q);
      REG_DEAD_ZONE:   prdata = APB_DW'(dead_zone_q);
      REG_MANUAL_MODE: prdata = APB_DW'(manual_mode_q);
      REG_PAN_MIN:     prdata = APB_DW'(pan_min_q);
      REG_PAN_MAX:     prdata = APB_DW'(pan_max_q);
      REG_TILT_MIN:    prdata = APB_DW'(tilt_min_q);
      REG_TILT_MAX:    prdata = APB_DW'(tilt_max_q);
      default:         prdata = '0;
    endcase
  end

  // Handshake: the input register drains whenever the result register frees up.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_take || (in_vld_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tx_q <= s_axis_tdata[COORD_WIDTH-1:0];
      ty_q <= s_axis_tdata[IN_W-1:COORD_WIDTH];
    end
  end

  // Per-axis logic.
  assign pan_cfg  = '{center: center_x_q, lo: pan_min_q, hi: pan_max_q};
  assign tilt_cfg = '{center: center_y_q, lo: tilt_min_q, hi: tilt_max_q};

  ptsc_axis u_pan (
    .coord_i     (tx_q),
    .cfg_i       (pan_cfg),
    .dead_zone_i (dead_zone_q),
    .manual_i    (manual_mode_q),
    .angle_i     (pan_q),
    .res_o       (pan_res)
  );

  ptsc_axis u_tilt (
    .coord_i     (ty_q),
    .cfg_i       (tilt_cfg),
    .dead_zone_i (dead_zone_q),
    .manual_i    (manual_mode_q),
    .angle_i     (tilt_q),
    .res_o       (tilt_res)
  );

  // Combine axes: only an axis outside the dead zone moves.
  always_comb begin
    any_out = pan_res.outside || tilt_res.outside;
    pan_d   = pan_res.outside ? pan_res.angle : pan_q;
    tilt_d  = tilt_res.outside ? tilt_res.angle : tilt_q;
    res_d   = {tilt_d, pan_d, any_out, !any_out};
  end

  // Held angles and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q     <= ANGLE_RESET;
      tilt_q    <= ANGLE_RESET;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        pan_q  <= pan_d;
        tilt_q <= tilt_d;
      end
      out_vld_q <= advance || (out_vld_q && !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_DATA_W'(res_q);

endmodule
